// ===== sv/lc3ie_pkg.sv =====
// Package for the LC-3 instruction execute block.
// Holds the opcode and state types, trap vectors, condition codes and helper functions.
// Depends on nothing; every other file imports it.
package lc3ie_pkg;

    typedef enum logic [3:0] {
        OP_BR   = 4'd0,
        OP_ADD  = 4'd1,
        OP_LD   = 4'd2,
        OP_ST   = 4'd3,
        OP_JSR  = 4'd4,
        OP_AND  = 4'd5,
        OP_LDR  = 4'd6,
        OP_STR  = 4'd7,
        OP_RTI  = 4'd8,
        OP_NOT  = 4'd9,
        OP_LDI  = 4'd10,
        OP_STI  = 4'd11,
        OP_JMP  = 4'd12,
        OP_RES  = 4'd13,
        OP_LEA  = 4'd14,
        OP_TRAP = 4'd15
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MEM1,
        ST_MEM2
    } state_t;

    typedef struct packed {
        logic        we;
        logic [2:0]  idx;
        logic [15:0] data;
    } rf_wr_t;

    localparam logic [7:0]  TRAP_GETC = 8'h20;
    localparam logic [7:0]  TRAP_OUT  = 8'h21;
    localparam logic [7:0]  TRAP_IN   = 8'h23;
    localparam logic [7:0]  TRAP_HALT = 8'h25;

    localparam logic [2:0]  CC_N = 3'b100;
    localparam logic [2:0]  CC_Z = 3'b010;
    localparam logic [2:0]  CC_P = 3'b001;

    localparam logic [15:0] PC_RESET = 16'h3000;
    localparam logic [2:0]  LINK_REG = 3'd7;

    function automatic logic [2:0] cc_of(input logic [15:0] v);
        logic [2:0] cc;
        if (v == 16'd0) begin
            cc = CC_Z;
        end else if (v[15]) begin
            cc = CC_N;
        end else begin
            cc = CC_P;
        end
        return cc;
    endfunction

    function automatic logic [15:0] sext5(input logic [4:0] v);
        return {{11{v[4]}}, v};
    endfunction

    function automatic logic [15:0] sext6(input logic [5:0] v);
        return {{10{v[5]}}, v};
    endfunction

    function automatic logic [15:0] sext9(input logic [8:0] v);
        return {{7{v[8]}}, v};
    endfunction

    function automatic logic [15:0] sext11(input logic [10:0] v);
        return {{5{v[10]}}, v};
    endfunction

endpackage

// ===== sv/lc3ie_regfile.sv =====
// General register file of the LC-3 execute block: eight 16-bit words, two read ports.
// Reads are registered; a write in the cycle of a read is forwarded. Uses lc3ie_pkg.
// Entries that were never written read as zero through per-entry valid bits.
module lc3ie_regfile (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [2:0]         rd_addr_a,
    input  logic [2:0]         rd_addr_b,
    input  lc3ie_pkg::rf_wr_t  wr,
    output logic [15:0]        rd_data_a,
    output logic [15:0]        rd_data_b
);
    import lc3ie_pkg::*;

    logic [15:0] rf_mem [8];
    logic [7:0]  vld_reg;
    logic [15:0] rdata_a_reg;
    logic [15:0] rdata_b_reg;
    logic [15:0] byp_data_reg;
    logic        vld_a_reg;
    logic        vld_b_reg;
    logic        hit_a_reg;
    logic        hit_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            rf_mem[wr.idx] <= wr.data;
        end
        if (rd_en) begin
            rdata_a_reg  <= rf_mem[rd_addr_a];
            rdata_b_reg  <= rf_mem[rd_addr_b];
            byp_data_reg <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            hit_a_reg <= 1'b0;
            hit_b_reg <= 1'b0;
        end else begin
            if (wr.we) begin
                vld_reg[wr.idx] <= 1'b1;
            end
            if (rd_en) begin
                vld_a_reg <= vld_reg[rd_addr_a];
                vld_b_reg <= vld_reg[rd_addr_b];
                hit_a_reg <= wr.we && (wr.idx == rd_addr_a);
                hit_b_reg <= wr.we && (wr.idx == rd_addr_b);
            end
        end
    end

    assign rd_data_a = hit_a_reg ? byp_data_reg : (vld_a_reg ? rdata_a_reg : 16'd0);
    assign rd_data_b = hit_b_reg ? byp_data_reg : (vld_b_reg ? rdata_b_reg : 16'd0);

endmodule

// ===== sv/lc3_instruction_execute.sv =====
// Top level of the LC-3 instruction execute block: sequencer, main memory and result register.
// Depends on lc3ie_pkg and instantiates lc3ie_regfile.
//
//  Channel   Direction  Handshake              Moves
//  s_        in         s_valid / s_ready      one command: memory load or instruction
//  m_        out        m_valid / m_ready      one result per command
//  cfg_      in         cfg_wen                new program counter, no wait
//
// Memory loads and non-memory instructions finish in EXEC, back to back unless m_ready holds.
// LD, LDR and STI add step MEM1 and LDI adds MEM1 and MEM2, as main memory reads are registered.
// Reset clears control, sets the PC to 0x3000 and the condition code to Z; registers read zero.
// Main memory holds no defined contents after reset until words are written.
// A result waits in the output register; the next transfer is taken as the current one finishes.
module lc3_instruction_execute #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_instr,
    input  logic [15:0] s_load_address,
    input  logic [15:0] s_load_word,
    input  logic [7:0]  s_char_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_reg_write_valid,
    output logic [2:0]  m_reg_index,
    output logic [15:0] m_reg_value,
    output logic [15:0] m_next_pc,
    output logic [2:0]  m_cond_flags,
    output logic        m_mem_write_valid,
    output logic [15:0] m_mem_address,
    output logic [15:0] m_mem_word,
    output logic        m_char_out_valid,
    output logic [7:0]  m_char_out,
    output logic        m_halted
);
    import lc3ie_pkg::*;

    localparam int MemWords = 1 << MEM_ADDR_BITS;

    state_t state_reg;
    state_t state_next;

    logic        cmd_reg;
    logic [15:0] ir_reg;
    logic [15:0] ld_addr_reg;
    logic [15:0] ld_word_reg;
    logic [7:0]  char_reg;
    logic [15:0] pc_reg;
    logic [2:0]  cc_reg;
    logic        halt_reg;

    logic [15:0] main_mem [MemWords];
    logic [15:0] mem_rdata_reg;
    logic        mem_re;
    logic [MEM_ADDR_BITS-1:0] mem_raddr;
    logic        mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_waddr;
    logic [15:0] mem_wdata;

    logic        m_valid_reg;
    logic        out_rw_reg;
    logic [2:0]  out_ridx_reg;
    logic [15:0] out_rval_reg;
    logic [15:0] out_pc_reg;
    logic [2:0]  out_cc_reg;
    logic        out_mw_reg;
    logic [15:0] out_maddr_reg;
    logic [15:0] out_mword_reg;
    logic        out_cw_reg;
    logic [7:0]  out_cval_reg;
    logic        out_halt_reg;

    logic        accept;
    logic        fin;
    logic        fin_go;
    logic        out_free;

    opcode_t     in_op;
    logic [2:0]  rf_addr_a;
    logic [2:0]  rf_addr_b;
    logic [15:0] rf_a;
    logic [15:0] rf_b;
    rf_wr_t      rf_wr;

    opcode_t     op;
    logic [15:0] pc_inc;
    logic [15:0] off9_addr;
    logic [15:0] base_addr;
    logic [15:0] eff_addr;
    logic        need_mem;

    logic        res_rw;
    logic [2:0]  res_ridx;
    logic [15:0] res_rval;
    logic [15:0] res_pc;
    logic [2:0]  res_cc;
    logic        res_mw;
    logic [15:0] res_maddr;
    logic [MEM_ADDR_BITS-1:0] res_maddr_m;
    logic [15:0] res_mword;
    logic        res_cw;
    logic [7:0]  res_cval;
    logic        res_halt;

    // Register file read addresses come straight from the incoming instruction.
    assign in_op     = opcode_t'(s_instr[15:12]);
    assign rf_addr_a = (in_op == OP_TRAP) ? 3'd0 : s_instr[8:6];
    assign rf_addr_b = (in_op == OP_ADD || in_op == OP_AND) ? s_instr[2:0] : s_instr[11:9];

    assign rf_wr.we   = fin_go && res_rw;
    assign rf_wr.idx  = res_ridx;
    assign rf_wr.data = res_rval;

    lc3ie_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (rf_addr_a),
        .rd_addr_b (rf_addr_b),
        .wr        (rf_wr),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    assign op        = opcode_t'(ir_reg[15:12]);
    assign pc_inc    = pc_reg + 16'd1;
    assign off9_addr = pc_inc + sext9(ir_reg[8:0]);
    assign base_addr = rf_a + sext6(ir_reg[5:0]);
    assign eff_addr  = (op == OP_LDR) ? base_addr : off9_addr;
    assign need_mem  = cmd_reg && !halt_reg &&
                       (op == OP_LD || op == OP_LDR || op == OP_LDI || op == OP_STI);

    always_comb begin
        res_rw    = 1'b0;
        res_ridx  = 3'd0;
        res_rval  = 16'd0;
        res_pc    = pc_reg;
        res_cc    = cc_reg;
        res_mw    = 1'b0;
        res_maddr = 16'd0;
        res_mword = 16'd0;
        res_cw    = 1'b0;
        res_cval  = 8'd0;
        res_halt  = halt_reg;
        if (cmd_reg && !halt_reg) begin
            res_pc = pc_inc;
            case (op)
                OP_BR: begin
                    if (|(ir_reg[11:9] & cc_reg)) begin
                        res_pc = off9_addr;
                    end
                end
                OP_ADD, OP_AND: begin
                    res_rw   = 1'b1;
                    res_ridx = ir_reg[11:9];
                    if (op == OP_ADD) begin
                        res_rval = rf_a + (ir_reg[5] ? sext5(ir_reg[4:0]) : rf_b);
                    end else begin
                        res_rval = rf_a & (ir_reg[5] ? sext5(ir_reg[4:0]) : rf_b);
                    end
                end
                OP_LD, OP_LDR, OP_LDI: begin
                    res_rw   = 1'b1;
                    res_ridx = ir_reg[11:9];
                    res_rval = mem_rdata_reg;
                end
                OP_ST: begin
                    res_mw    = 1'b1;
                    res_maddr = off9_addr;
                    res_mword = rf_b;
                end
                OP_STR: begin
                    res_mw    = 1'b1;
                    res_maddr = base_addr;
                    res_mword = rf_b;
                end
                OP_STI: begin
                    res_mw    = 1'b1;
                    res_maddr = mem_rdata_reg;
                    res_mword = rf_b;
                end
                OP_JSR: begin
                    res_rw   = 1'b1;
                    res_ridx = LINK_REG;
                    res_rval = pc_inc;
                    res_pc   = ir_reg[11] ? (pc_inc + sext11(ir_reg[10:0])) : rf_a;
                end
                OP_NOT: begin
                    res_rw   = 1'b1;
                    res_ridx = ir_reg[11:9];
                    res_rval = ~rf_a;
                end
                OP_JMP: begin
                    res_pc = rf_a;
                end
                OP_LEA: begin
                    res_rw   = 1'b1;
                    res_ridx = ir_reg[11:9];
                    res_rval = off9_addr;
                end
                OP_TRAP: begin
                    case (ir_reg[7:0])
                        TRAP_GETC: begin
                            res_rw   = 1'b1;
                            res_rval = {8'd0, char_reg};
                        end
                        TRAP_OUT: begin
                            res_cw   = 1'b1;
                            res_cval = rf_a[7:0];
                        end
                        TRAP_IN: begin
                            res_rw   = 1'b1;
                            res_rval = {8'd0, char_reg};
                            res_cw   = 1'b1;
                            res_cval = char_reg;
                        end
                        TRAP_HALT: begin
                            res_halt = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
            // Traps, branches, jumps and stores leave the condition code alone.
            if (res_rw && op != OP_TRAP && op != OP_JSR) begin
                res_cc = cc_of(res_rval);
            end
        end
    end

    assign res_maddr_m = res_maddr[MEM_ADDR_BITS-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (need_mem) begin
                    state_next = ST_MEM1;
                end else if (fin_go) begin
                    state_next = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            ST_MEM1: begin
                if (op == OP_LDI) begin
                    state_next = ST_MEM2;
                end else if (fin_go) begin
                    state_next = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            ST_MEM2: begin
                if (fin_go) begin
                    state_next = s_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        fin    = 1'b0;
        mem_re = 1'b0;
        case (state_reg)
            ST_IDLE: begin
            end
            ST_EXEC: begin
                fin    = !need_mem;
                mem_re = need_mem;
            end
            ST_MEM1: begin
                fin    = (op != OP_LDI);
                mem_re = (op == OP_LDI);
            end
            ST_MEM2: begin
                fin = 1'b1;
            end
            default: begin
            end
        endcase
        fin_go  = fin && out_free;
        s_ready = (state_reg == ST_IDLE) || fin_go;
    end

    assign mem_raddr = (state_reg == ST_EXEC) ? eff_addr[MEM_ADDR_BITS-1:0]
                                              : mem_rdata_reg[MEM_ADDR_BITS-1:0];
    assign mem_we    = fin_go && (!cmd_reg || res_mw);
    assign mem_waddr = cmd_reg ? res_maddr_m : ld_addr_reg[MEM_ADDR_BITS-1:0];
    assign mem_wdata = cmd_reg ? res_mword : ld_word_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            main_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= main_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg     <= s_cmd;
            ir_reg      <= s_instr;
            ld_addr_reg <= s_load_address;
            ld_word_reg <= s_load_word;
            char_reg    <= s_char_in;
        end
        if (fin_go) begin
            out_rw_reg    <= res_rw;
            out_ridx_reg  <= res_ridx;
            out_rval_reg  <= res_rval;
            out_pc_reg    <= res_pc;
            out_cc_reg    <= res_cc;
            out_mw_reg    <= res_mw;
            out_maddr_reg <= 16'(res_maddr_m);
            out_mword_reg <= res_mword;
            out_cw_reg    <= res_cw;
            out_cval_reg  <= res_cval;
            out_halt_reg  <= res_halt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= PC_RESET;
            cc_reg      <= CC_Z;
            halt_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fin_go) begin
                pc_reg      <= res_pc;
                cc_reg      <= res_cc;
                halt_reg    <= res_halt;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wen) begin
                pc_reg <= cfg_wdata;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_reg_write_valid = out_rw_reg;
    assign m_reg_index       = out_ridx_reg;
    assign m_reg_value       = out_rval_reg;
    assign m_next_pc         = out_pc_reg;
    assign m_cond_flags      = out_cc_reg;
    assign m_mem_write_valid = out_mw_reg;
    assign m_mem_address     = out_maddr_reg;
    assign m_mem_word        = out_mword_reg;
    assign m_char_out_valid  = out_cw_reg;
    assign m_char_out        = out_cval_reg;
    assign m_halted          = out_halt_reg;

    // An accepted transfer always starts in the execute step.
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_EXEC)
        else $error("accepted transfer did not enter the execute step");

    // Once halted, the block stays halted.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    // The condition code always holds exactly one of N, Z and P.
    a_cc_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(cc_reg))
        else $error("condition code is not one-hot");

    // The second memory step only follows the first.
    a_mem2_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MEM2 |-> $past(state_reg) == ST_MEM1 || $past(state_reg) == ST_MEM2)
        else $error("second memory step entered out of order");

    // A finished command always presents a result in the next cycle.
    a_fin_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_go |=> m_valid_reg)
        else $error("finished command produced no result");

endmodule
